// ===== src/hash_group_by_aggregate_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef HASH_GROUP_BY_AGGREGATE_UNIT_ASSERT_SVH
`define HASH_GROUP_BY_AGGREGATE_UNIT_ASSERT_SVH

// The antecedent in the current cycle implies the consequent in the same cycle.
`define HGBA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgba assertion failed");

// The antecedent in the current cycle implies the consequent in the next cycle.
`define HGBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgba assertion failed");

`endif

// ===== src/hgba_pkg.sv =====
package hgba_pkg;

    localparam int KEY_INPUTS = 4;
    localparam int WORD_W     = 64;
    localparam int KW_W       = 3;
    localparam int EC_W       = 11;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CHUNK_BITS = 8;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [KEY_INPUTS-1:0] key_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_UPDATED = 2'd0,
        STATUS_NEW     = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_CLEARED = 2'd3
    } status_t;

    typedef enum logic [MODE_W-1:0] {
        AGG_CNT = 2'd0,
        AGG_SUM = 2'd1,
        AGG_MAX = 2'd2,
        AGG_MIN = 2'd3
    } agg_mode_t;

    typedef enum logic {
        REQ_CLEAR     = 1'b0,
        REQ_AGGREGATE = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_WORDS   = 2'd0,
        CFG_ENTRY_COUNT = 2'd1,
        CFG_INIT_VALUE  = 2'd2,
        CFG_AGG_MODE    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic            start;
        logic [KW_W-1:0] key_words;
    } hash_cmd_t;

    function automatic word_t apply_agg(input agg_mode_t mode, input word_t cur,
                                        input word_t v);
        word_t res;
        case (mode)
            AGG_CNT: res = cur + 64'd1;
            AGG_SUM: res = cur + v;
            AGG_MAX: res = ($signed(cur) < $signed(v)) ? v : cur;
            AGG_MIN: res = ($signed(v) < $signed(cur)) ? v : cur;
            default: res = cur;
        endcase
        return res;
    endfunction

endpackage

// ===== src/hgba_req_if.sv =====
interface hgba_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [63:0] key_word0;
    logic signed [63:0] key_word1;
    logic signed [63:0] key_word2;
    logic signed [63:0] key_word3;
    logic signed [63:0] row_value;

    modport source (output valid, req_type, key_word0, key_word1, key_word2, key_word3,
                    row_value, input ready);
    modport sink (input valid, req_type, key_word0, key_word1, key_word2, key_word3,
                  row_value, output ready);
endinterface

// ===== src/hgba_rsp_if.sv =====
interface hgba_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [9:0]         slot;
    logic signed [63:0] group_value;

    modport source (output valid, status, slot, group_value, input ready);
    modport sink (input valid, status, slot, group_value, output ready);
endinterface

// ===== src/hgba_ram.sv =====
module hgba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/hgba_hash.sv =====
module hgba_hash #(
    parameter int ENTRIES = 1024,
    localparam int CNT_W = $clog2(ENTRIES + 1),
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hgba_pkg::hash_cmd_t cmd,
    input  hgba_pkg::key_t      key,
    input  logic [CNT_W-1:0]    n,
    output logic                done,
    output logic [IDX_W-1:0]    h
);

    localparam int RW = CNT_W + 1;
    localparam int VW = CNT_W + 6;
    localparam int CHUNKS = hgba_pkg::WORD_W / hgba_pkg::CHUNK_BITS;
    localparam int CH_W = $clog2(CHUNKS);
    localparam int WI_W = $clog2(hgba_pkg::KEY_INPUTS);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_RUN  = 3'b010,
        H_COMB = 3'b100
    } hstate_t;

    hstate_t                   state_reg, state_next;
    logic [WI_W-1:0]           word_reg, word_next;
    logic [CH_W-1:0]           chunk_reg, chunk_next;
    logic [IDX_W-1:0]          rem_reg, rem_next;
    logic [IDX_W-1:0]          wrap_reg, wrap_next;
    logic [IDX_W-1:0]          hash_reg, hash_next;
    logic [hgba_pkg::KW_W-1:0] kw_reg, kw_next;
    hgba_pkg::word_t           sh_reg, sh_next;
    hgba_pkg::key_t            key_reg, key_next;
    logic                      done_reg, done_next;

    logic [RW-1:0]    r_v, w_v, t_r, t_w, n_rw, d_v;
    logic [VW-1:0]    v_v, sub_v;
    logic [IDX_W-1:0] wrap_init;
    logic [WI_W-1:0]  word_inc;

    assign n_rw      = RW'(n);
    assign wrap_init = (n == CNT_W'(1)) ? '0 : IDX_W'(1);
    assign word_inc  = word_reg + WI_W'(1);

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        chunk_next = chunk_reg;
        rem_next   = rem_reg;
        wrap_next  = wrap_reg;
        hash_next  = hash_reg;
        kw_next    = kw_reg;
        sh_next    = sh_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        r_v        = RW'(rem_reg);
        w_v        = RW'(wrap_reg);
        t_r        = '0;
        t_w        = '0;
        d_v        = '0;
        v_v        = '0;
        sub_v      = '0;
        case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    // The key is held here, as the request port moves on.
                    kw_next    = cmd.key_words;
                    key_next   = key;
                    word_next  = '0;
                    chunk_next = '0;
                    rem_next   = '0;
                    wrap_next  = wrap_init;
                    hash_next  = '0;
                    sh_next    = key[0];
                    state_next = H_RUN;
                end
            end
            H_RUN:
            begin
                // Eight bits of the word, most significant first, fold into the
                // remainder; the wrap term doubles alongside to give 2^64 mod n.
                for (int b = 0; b < hgba_pkg::CHUNK_BITS; b++)
                begin
                    t_r = {r_v[RW-2:0], sh_reg[hgba_pkg::WORD_W-1-b]};
                    if (t_r >= n_rw)
                    begin
                        t_r = t_r - n_rw;
                    end
                    r_v = t_r;
                    t_w = {w_v[RW-2:0], 1'b0};
                    if (t_w >= n_rw)
                    begin
                        t_w = t_w - n_rw;
                    end
                    w_v = t_w;
                end
                rem_next   = IDX_W'(r_v);
                wrap_next  = IDX_W'(w_v);
                sh_next    = sh_reg << hgba_pkg::CHUNK_BITS;
                chunk_next = chunk_reg + CH_W'(1);
                if (chunk_reg == CH_W'(CHUNKS - 1))
                begin
                    state_next = H_COMB;
                end
            end
            H_COMB:
            begin
                // A negative word subtracts 2^64 mod n from its unsigned remainder.
                d_v = RW'(rem_reg);
                if (key_reg[word_reg][hgba_pkg::WORD_W-1])
                begin
                    if (RW'(rem_reg) >= RW'(wrap_reg))
                    begin
                        d_v = RW'(rem_reg) - RW'(wrap_reg);
                    end
                    else
                    begin
                        d_v = RW'(rem_reg) + n_rw - RW'(wrap_reg);
                    end
                end
                v_v = (VW'(hash_reg) << 5) - VW'(hash_reg) + VW'(d_v);
                for (int k = 4; k >= 0; k--)
                begin
                    sub_v = VW'(n) << k;
                    if (v_v >= sub_v)
                    begin
                        v_v = v_v - sub_v;
                    end
                end
                hash_next = IDX_W'(v_v);
                if ((hgba_pkg::KW_W'(word_reg) + hgba_pkg::KW_W'(1)) >= kw_reg)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    word_next  = word_inc;
                    chunk_next = '0;
                    rem_next   = '0;
                    wrap_next  = wrap_init;
                    sh_next    = key_reg[word_inc];
                    state_next = H_RUN;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        chunk_reg <= chunk_next;
        rem_reg   <= rem_next;
        wrap_reg  <= wrap_next;
        hash_reg  <= hash_next;
        kw_reg    <= kw_next;
        sh_reg    <= sh_next;
        key_reg   <= key_next;
    end

    assign done = done_reg;
    assign h    = hash_reg;

endmodule

// ===== src/hash_group_by_aggregate_unit.sv =====
// Group-by hash aggregation table with linear probing.
// Requests arrive on the req channel and each one gives exactly one transaction
// on the rsp channel; both channels use a valid/ready handshake. A clear request
// empties the whole table, an aggregate request folds row_value into the group
// named by its key and reports the status, the slot and the new group value.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it. The hash
// folds each configured key word into its remainder eight bits at a time,
// then combines it into the hash and hands the result over; each probed entry
// takes a synchronous memory read, then a compare and write back, and the
// result then moves to the output register. A clear runs the sweep that
// rewrites one valid bit per cycle.
// The block works on one request at a time: req.ready is high only while no
// request is in progress, but it does not wait for the receiver, because the
// finished result sits in an output register until rsp.ready takes it.
// A stalled receiver holds the result there; a following result waits for it.
// After reset the block sweeps all ENTRIES entries to empty
// before it accepts a request; configuration writes are taken throughout.
module hash_group_by_aggregate_unit #(
    parameter int ENTRIES       = 1024,
    parameter int KEY_WORDS_MAX = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    hgba_req_if.sink                       req,
    hgba_rsp_if.source                     rsp,
    input  logic                           cfg_wr_en,
    input  logic [hgba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hgba_pkg::WORD_W-1:0]    cfg_data
);

    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int KEY_LANES = (KEY_WORDS_MAX < hgba_pkg::KEY_INPUTS) ?
                               KEY_WORDS_MAX : hgba_pkg::KEY_INPUTS;
    localparam int KEY_ROW_W = KEY_LANES * hgba_pkg::WORD_W;
    localparam int VAL_ROW_W = hgba_pkg::WORD_W + 1;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HASH   = 6'b000100,
        S_READ   = 6'b001000,
        S_CHECK  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    // Configuration registers.
    logic [hgba_pkg::KW_W-1:0]   key_words_reg;
    logic [hgba_pkg::EC_W-1:0]   entry_count_reg;
    hgba_pkg::word_t             init_value_reg;
    hgba_pkg::agg_mode_t         agg_mode_reg;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            sweep_reg, sweep_next;
    logic [IDX_W-1:0]            slot_reg, slot_next;
    logic [CNT_W-1:0]            probe_reg, probe_next;
    logic                        clr_rsp_reg, clr_rsp_next;
    hgba_pkg::key_t              key_reg, key_next;
    hgba_pkg::word_t             val_reg, val_next;
    hgba_pkg::status_t           res_status_reg, res_status_next;
    logic [IDX_W-1:0]            res_slot_reg, res_slot_next;
    hgba_pkg::word_t             res_value_reg, res_value_next;
    logic                        out_valid_reg, out_valid_next;
    hgba_pkg::status_t           out_status_reg, out_status_next;
    logic [hgba_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    hgba_pkg::word_t             out_value_reg, out_value_next;

    logic [hgba_pkg::KW_W-1:0]   kw_eff;
    logic [CNT_W-1:0]            n_eff;
    hgba_pkg::hash_cmd_t         hash_cmd;
    logic                        hash_done;
    logic [IDX_W-1:0]            hash_h;

    logic                        mem_addr_sel;
    logic [IDX_W-1:0]            mem_addr;
    logic                        key_we, val_we;
    logic [KEY_ROW_W-1:0]        key_wdata, key_rdata;
    logic [VAL_ROW_W-1:0]        val_wdata, val_rdata;
    logic                        key_match;
    hgba_pkg::word_t             agg_base, agg_res;
    logic [CNT_W-1:0]            probe_inc;
    logic [CNT_W-1:0]            slot_inc;
    logic                        accept;

    // Out-of-range register values are clamped here, not at the write.
    always_comb
    begin
        kw_eff = key_words_reg;
        if (key_words_reg == '0)
        begin
            kw_eff = hgba_pkg::KW_W'(1);
        end
        else if (key_words_reg > hgba_pkg::KW_W'(KEY_LANES))
        begin
            kw_eff = hgba_pkg::KW_W'(KEY_LANES);
        end
        n_eff = CNT_W'(entry_count_reg);
        if (entry_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(entry_count_reg) > ENTRIES)
        begin
            n_eff = CNT_W'(ENTRIES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_words_reg   <= hgba_pkg::KW_W'(1);
            entry_count_reg <= hgba_pkg::EC_W'(1024);
            init_value_reg  <= '0;
            agg_mode_reg    <= hgba_pkg::AGG_SUM;
        end
        else if (cfg_wr_en)
        begin
            case (hgba_pkg::cfg_index_t'(cfg_index))
                hgba_pkg::CFG_KEY_WORDS:   key_words_reg   <= cfg_data[hgba_pkg::KW_W-1:0];
                hgba_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[hgba_pkg::EC_W-1:0];
                hgba_pkg::CFG_INIT_VALUE:  init_value_reg  <= cfg_data;
                hgba_pkg::CFG_AGG_MODE:
                    agg_mode_reg <= hgba_pkg::agg_mode_t'(cfg_data[hgba_pkg::MODE_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign hash_cmd.start     = accept && (req.req_type == hgba_pkg::REQ_AGGREGATE);
    assign hash_cmd.key_words = kw_eff;

    hgba_hash #(
        .ENTRIES (ENTRIES)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hash_cmd),
        .key   ({req.key_word3, req.key_word2, req.key_word1, req.key_word0}),
        .n     (n_eff),
        .done  (hash_done),
        .h     (hash_h)
    );

    // Key rows hold every key word of one entry; value rows hold the valid bit
    // on top of the group value.
    hgba_ram #(
        .WIDTH (KEY_ROW_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .addr  (mem_addr),
        .wdata (key_wdata),
        .rdata (key_rdata)
    );

    hgba_ram #(
        .WIDTH (VAL_ROW_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .addr  (mem_addr),
        .wdata (val_wdata),
        .rdata (val_rdata)
    );

    assign mem_addr_sel = (state_reg == S_CLEAR);
    assign mem_addr     = mem_addr_sel ? sweep_reg : slot_reg;

    always_comb
    begin
        for (int j = 0; j < KEY_LANES; j++)
        begin
            key_wdata[j*hgba_pkg::WORD_W +: hgba_pkg::WORD_W] = key_reg[j];
        end
    end

    // Only the configured number of key words takes part in the compare.
    always_comb
    begin
        key_match = 1'b1;
        for (int j = 0; j < KEY_LANES; j++)
        begin
            if ((hgba_pkg::KW_W'(j) < kw_eff) &&
                (key_rdata[j*hgba_pkg::WORD_W +: hgba_pkg::WORD_W] != key_reg[j]))
            begin
                key_match = 1'b0;
            end
        end
    end

    assign agg_base  = val_rdata[VAL_ROW_W-1] ? val_rdata[hgba_pkg::WORD_W-1:0] : init_value_reg;
    assign agg_res   = hgba_pkg::apply_agg(agg_mode_reg, agg_base, val_reg);
    assign probe_inc = probe_reg + CNT_W'(1);
    assign slot_inc  = CNT_W'(slot_reg) + CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        clr_rsp_next    = clr_rsp_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_value_next  = out_value_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;
        val_wdata       = {1'b1, agg_res};

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                val_we    = 1'b1;
                val_wdata = '0;
                sweep_next = sweep_reg + IDX_W'(1);
                if (32'(sweep_reg) == ENTRIES - 1)
                begin
                    if (clr_rsp_reg)
                    begin
                        res_status_next = hgba_pkg::STATUS_CLEARED;
                        res_slot_next   = '0;
                        res_value_next  = '0;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next = {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
                    val_next = req.row_value;
                    if (req.req_type == hgba_pkg::REQ_CLEAR)
                    begin
                        sweep_next   = '0;
                        clr_rsp_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    slot_next  = hash_h;
                    probe_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // An empty entry is claimed, a matching one updated; otherwise the probe
                // moves on, wrapping at the configured entry count, or reports the table full.
                if (!val_rdata[VAL_ROW_W-1] || key_match)
                begin
                    val_we          = 1'b1;
                    key_we          = !val_rdata[VAL_ROW_W-1];
                    res_status_next = val_rdata[VAL_ROW_W-1] ? hgba_pkg::STATUS_UPDATED :
                                                               hgba_pkg::STATUS_NEW;
                    res_slot_next   = slot_reg;
                    res_value_next  = agg_res;
                    state_next      = S_RESULT;
                end
                else if (probe_inc == n_eff)
                begin
                    res_status_next = hgba_pkg::STATUS_FULL;
                    res_slot_next   = '0;
                    res_value_next  = '0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    probe_next = probe_inc;
                    slot_next  = (slot_inc == n_eff) ? '0 : IDX_W'(slot_inc);
                    state_next = S_READ;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = hgba_pkg::SLOT_W'(res_slot_reg);
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            clr_rsp_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            clr_rsp_reg   <= (state_reg == S_RESULT) ? 1'b0 : clr_rsp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        probe_reg      <= probe_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_value_reg  <= out_value_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.group_value = out_value_reg;

endmodule

// ===== src/hgba_checker.sv =====
`include "hash_group_by_aggregate_unit_assert.svh"

module hgba_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic [9:0] slot,
    input logic [63:0] group_value
);

    // A result waiting for the receiver keeps its status.
    `HGBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status))

    // Full and cleared results carry a zero slot and a zero value.
    `HGBA_ASSERT_SAME(a_zero_fields,
        rsp_valid && (status == hgba_pkg::STATUS_FULL || status == hgba_pkg::STATUS_CLEARED),
        slot == '0 && group_value == '0)

    // One request at a time: an accepted request closes the input in the next cycle.
    `HGBA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind hash_group_by_aggregate_unit hgba_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .slot        (rsp.slot),
    .group_value (rsp.group_value)
);

// ===== tb/hash_group_by_aggregate_unit_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the group-by hash aggregation table. A short table
// of directed transactions is walked first, then randomised phases with their
// own register settings follow. Every accepted request is run through a
// predictor that keeps its own copy of the table, and every response is
// compared field by field with the oldest outstanding prediction.
module hash_group_by_aggregate_unit_tb;

    localparam int TABLE_SIZE   = 1024;
    localparam int LIMIT_CYCLES = 10000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 50;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 85;
    localparam int POOL_SIZE    = 6;
    localparam hgba_pkg::word_t INT_MIN = 64'h8000_0000_0000_0000;
    localparam hgba_pkg::word_t INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        hgba_pkg::status_t           status;
        logic [hgba_pkg::SLOT_W-1:0] slot;
        hgba_pkg::word_t             value;
    } group_result_t;

    typedef struct {
        row_kind_t            kind;
        hgba_pkg::cfg_index_t index;
        hgba_pkg::word_t      data;
        hgba_pkg::req_type_t  rtype;
        hgba_pkg::key_t       key;
        hgba_pkg::word_t      value;
        bit                   typed;
        group_result_t        result;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [hgba_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hgba_pkg::WORD_W-1:0] cfg_data;

    hgba_req_if req_ch ();
    hgba_rsp_if rsp_ch ();

    hash_group_by_aggregate_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: our own copy of the registers and of the table.
    logic [hgba_pkg::KW_W-1:0] key_words_reg;
    logic [hgba_pkg::EC_W-1:0] entry_count_reg;
    hgba_pkg::word_t           init_value_reg;
    hgba_pkg::agg_mode_t       agg_mode_reg;
    bit                        slot_used [TABLE_SIZE];
    hgba_pkg::word_t           slot_keys [TABLE_SIZE][hgba_pkg::KEY_INPUTS];
    hgba_pkg::word_t           slot_value [TABLE_SIZE];

    group_result_t  pending_results[$];
    stim_row_t      stim_table[$];
    hgba_pkg::key_t key_pool [POOL_SIZE];

    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;
    bit  holding;

    // The clock runs from time zero with a 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // A watchdog that ends a run which has hung.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic hgba_pkg::word_t fold_group(input hgba_pkg::word_t cur,
                                                   input hgba_pkg::word_t v);
        hgba_pkg::word_t res;
        case (agg_mode_reg)
            hgba_pkg::AGG_CNT: res = cur + 64'd1;
            hgba_pkg::AGG_SUM: res = cur + v;
            hgba_pkg::AGG_MAX: res = ($signed(cur) < $signed(v)) ? v : cur;
            default:           res = ($signed(v) < $signed(cur)) ? v : cur;
        endcase
        return res;
    endfunction

    // Works out the response to one request and updates the predicted table.
    function automatic group_result_t aggregate_row(input hgba_pkg::req_type_t rtype,
                                                    input hgba_pkg::key_t key,
                                                    input hgba_pkg::word_t v);
        group_result_t res;
        int  kw;
        int  n;
        longint rem;
        int  h;
        int  s;
        bit  same;
        res.status = hgba_pkg::STATUS_FULL;
        res.slot   = '0;
        res.value  = '0;
        if (rtype == hgba_pkg::REQ_CLEAR)
        begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            res.status = hgba_pkg::STATUS_CLEARED;
            return res;
        end
        // Out-of-range settings are clamped into the supported range.
        kw = (key_words_reg == 0) ? 1 : ((key_words_reg > 4) ? 4 : key_words_reg);
        n  = (entry_count_reg == 0) ? 1 :
             ((entry_count_reg > TABLE_SIZE) ? TABLE_SIZE : entry_count_reg);
        h = 0;
        for (int j = 0; j < kw; j++)
        begin
            // Negative words still give a remainder in 0..n-1.
            rem = $signed(key[j]) % longint'(n);
            if (rem < 0)
                rem = rem + n;
            h = (h * 31 + int'(rem)) % n;
        end
        for (int i = 0; i < n; i++)
        begin
            s = (h + i) % n;
            if (!slot_used[s])
            begin
                for (int j = 0; j < kw; j++)
                    slot_keys[s][j] = key[j];
                slot_used[s]  = 1'b1;
                slot_value[s] = fold_group(init_value_reg, v);
                res.status = hgba_pkg::STATUS_NEW;
                res.slot   = s[hgba_pkg::SLOT_W-1:0];
                res.value  = slot_value[s];
                return res;
            end
            same = 1'b1;
            for (int j = 0; j < kw; j++)
                if (slot_keys[s][j] != key[j])
                    same = 1'b0;
            if (same)
            begin
                slot_value[s] = fold_group(slot_value[s], v);
                res.status = hgba_pkg::STATUS_UPDATED;
                res.slot   = s[hgba_pkg::SLOT_W-1:0];
                res.value  = slot_value[s];
                return res;
            end
        end
        return res;
    endfunction

    function automatic hgba_pkg::word_t pick_word();
        hgba_pkg::word_t w;
        case ($urandom_range(9))
            0: w = INT_MIN;
            1: w = INT_MAX;
            2: w = '0;
            3: w = '1;
            4: w = hgba_pkg::word_t'($urandom_range(40));
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Receiver: checks each completed response and randomises rsp.ready.
    always @(posedge clk)
    begin
        group_result_t exp_res;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count = error_count + 1;
                $display("%0t: unexpected response status %0d slot %0d value %h", $time,
                         rsp_ch.status, rsp_ch.slot, rsp_ch.group_value);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (rsp_ch.status !== exp_res.status || rsp_ch.slot !== exp_res.slot ||
                    rsp_ch.group_value !== exp_res.value)
                begin
                    error_count = error_count + 1;
                    $display("%0t: mismatch expected %0d/%0d/%h actual %0d/%0d/%h",
                             $time, exp_res.status, exp_res.slot, exp_res.value,
                             rsp_ch.status, rsp_ch.slot, rsp_ch.group_value);
                end
            end
        end
        rsp_ch.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long back-pressure stretch, counted here so the sender keeps running.
    initial
    begin
        holding = 1'b0;
        forever
        begin
            wait (hold_request);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 1'b0;
            hold_request = 1'b0;
        end
    end

    // Offers one transaction and returns at the edge where it is accepted,
    // leaving valid high so that a following transaction can go back to back.
    task automatic send_request(input hgba_pkg::req_type_t rtype, input hgba_pkg::key_t key,
                                input hgba_pkg::word_t v, input bit typed,
                                input group_result_t typed_res);
        group_result_t res;
        int idle;
        cfg_wr_en <= 1'b0;
        idle = 0;
        if ($urandom_range(99) < send_idle_pct)
            idle = $urandom_range(8, 1);
        if (idle > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rtype;
        req_ch.key_word0 <= key[0];
        req_ch.key_word1 <= key[1];
        req_ch.key_word2 <= key[2];
        req_ch.key_word3 <= key[3];
        req_ch.row_value <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        res = aggregate_row(rtype, key, v);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Lets every outstanding response come back before the block is reconfigured.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input hgba_pkg::cfg_index_t index,
                                  input hgba_pkg::word_t data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (index)
            hgba_pkg::CFG_KEY_WORDS:   key_words_reg   = data[hgba_pkg::KW_W-1:0];
            hgba_pkg::CFG_ENTRY_COUNT: entry_count_reg = data[hgba_pkg::EC_W-1:0];
            hgba_pkg::CFG_INIT_VALUE:  init_value_reg  = data;
            default:
                agg_mode_reg = hgba_pkg::agg_mode_t'(data[hgba_pkg::MODE_W-1:0]);
        endcase
    endtask

    function automatic void add_req(input hgba_pkg::req_type_t rtype,
                                    input hgba_pkg::key_t key, input hgba_pkg::word_t v);
        stim_row_t row;
        row.kind  = ROW_REQ;
        row.rtype = rtype;
        row.key   = key;
        row.value = v;
        row.typed = 1'b0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_typed(input hgba_pkg::req_type_t rtype,
                                      input hgba_pkg::key_t key, input hgba_pkg::word_t v,
                                      input hgba_pkg::status_t st, input int slot,
                                      input hgba_pkg::word_t gv);
        stim_row_t row;
        row.kind          = ROW_REQ;
        row.rtype         = rtype;
        row.key           = key;
        row.value         = v;
        row.typed         = 1'b1;
        row.result.status = st;
        row.result.slot   = slot[hgba_pkg::SLOT_W-1:0];
        row.result.value  = gv;
        stim_table.push_back(row);
    endfunction

    function automatic void add_cfg(input hgba_pkg::cfg_index_t index,
                                    input hgba_pkg::word_t data);
        stim_row_t row;
        row.kind  = ROW_CFG;
        row.index = index;
        row.data  = data;
        stim_table.push_back(row);
    endfunction

    initial
    begin
        hgba_pkg::key_t  key;
        hgba_pkg::word_t ec;
        group_result_t   none;
        int              pick;

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = hgba_pkg::REQ_CLEAR;
        req_ch.key_word0 = '0;
        req_ch.key_word1 = '0;
        req_ch.key_word2 = '0;
        req_ch.key_word3 = '0;
        req_ch.row_value = '0;
        rsp_ch.ready     = 1'b0;
        error_count      = 0;
        cycle_count      = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_request     = 1'b0;
        none.status      = hgba_pkg::STATUS_FULL;
        none.slot        = '0;
        none.value       = '0;

        key_words_reg   = 3'd1;
        entry_count_reg = 11'd1024;
        init_value_reg  = '0;
        agg_mode_reg    = hgba_pkg::AGG_SUM;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;

        // Directed table. Under the reset settings (one key word, all 1024
        // entries, sum from zero) the first rows can be worked out by hand:
        // a negative key lands at the top of the table, sums wrap at the
        // signed extremes, and a probe that starts at the last entry wraps
        // round to entry zero.
        add_typed(hgba_pkg::REQ_AGGREGATE, '0, 64'd5, hgba_pkg::STATUS_NEW, 0, 64'd5);
        add_typed(hgba_pkg::REQ_AGGREGATE, '0, -64'sd3, hgba_pkg::STATUS_UPDATED, 0, 64'd2);
        add_typed(hgba_pkg::REQ_AGGREGATE, {4{64'hFFFF_FFFF_FFFF_FFFF}}, INT_MAX,
                  hgba_pkg::STATUS_NEW, 1023, INT_MAX);
        add_typed(hgba_pkg::REQ_AGGREGATE, {4{64'hFFFF_FFFF_FFFF_FFFF}}, 64'd1,
                  hgba_pkg::STATUS_UPDATED, 1023, INT_MIN);
        add_typed(hgba_pkg::REQ_AGGREGATE, {192'd0, 64'd1023}, INT_MIN,
                  hgba_pkg::STATUS_NEW, 1, INT_MIN);
        add_typed(hgba_pkg::REQ_CLEAR, '0, '0, hgba_pkg::STATUS_CLEARED, 0, '0);
        add_typed(hgba_pkg::REQ_AGGREGATE, {192'd0, INT_MIN}, '0, hgba_pkg::STATUS_NEW, 0, '0);
        // Four key words, max from the most negative start; the table is
        // emptied first so no entry is compared on words it never stored.
        add_cfg(hgba_pkg::CFG_KEY_WORDS, 64'd4);
        add_cfg(hgba_pkg::CFG_AGG_MODE, hgba_pkg::AGG_MAX);
        add_cfg(hgba_pkg::CFG_INIT_VALUE, INT_MIN);
        add_req(hgba_pkg::REQ_CLEAR, '0, '0);
        add_req(hgba_pkg::REQ_AGGREGATE, {4{INT_MAX}}, -64'sd5);
        add_req(hgba_pkg::REQ_AGGREGATE, {4{INT_MAX}}, 64'd100);
        add_req(hgba_pkg::REQ_AGGREGATE, {INT_MIN, {3{INT_MAX}}}, 64'd7);
        // Two entries with count from the largest value: the count wraps and
        // a third group finds the table full.
        add_cfg(hgba_pkg::CFG_ENTRY_COUNT, 64'd2);
        add_cfg(hgba_pkg::CFG_AGG_MODE, hgba_pkg::AGG_CNT);
        add_cfg(hgba_pkg::CFG_INIT_VALUE, INT_MAX);
        add_typed(hgba_pkg::REQ_CLEAR, '0, '0, hgba_pkg::STATUS_CLEARED, 0, '0);
        add_req(hgba_pkg::REQ_AGGREGATE, {4{64'd11}}, '0);
        add_req(hgba_pkg::REQ_AGGREGATE, {4{64'd12}}, '0);
        add_typed(hgba_pkg::REQ_AGGREGATE, {4{64'd13}}, '0, hgba_pkg::STATUS_FULL, 0, '0);
        // Zero written to key words and entry count behaves as one.
        add_cfg(hgba_pkg::CFG_ENTRY_COUNT, 64'd0);
        add_cfg(hgba_pkg::CFG_KEY_WORDS, 64'd0);
        add_cfg(hgba_pkg::CFG_AGG_MODE, hgba_pkg::AGG_MIN);
        add_cfg(hgba_pkg::CFG_INIT_VALUE, '0);
        add_typed(hgba_pkg::REQ_CLEAR, '0, '0, hgba_pkg::STATUS_CLEARED, 0, '0);
        add_typed(hgba_pkg::REQ_AGGREGATE, {192'd0, 64'd5}, -64'sd9,
                  hgba_pkg::STATUS_NEW, 0, -64'sd9);
        add_typed(hgba_pkg::REQ_AGGREGATE, {192'd0, 64'd5}, 64'd3,
                  hgba_pkg::STATUS_UPDATED, 0, -64'sd9);
        add_typed(hgba_pkg::REQ_AGGREGATE, {192'd0, 64'd6}, 64'd3,
                  hgba_pkg::STATUS_FULL, 0, '0);
        // Values above the range saturate: seven key words and 2047 entries.
        add_cfg(hgba_pkg::CFG_ENTRY_COUNT, 64'd2047);
        add_cfg(hgba_pkg::CFG_KEY_WORDS, 64'd7);
        add_cfg(hgba_pkg::CFG_AGG_MODE, hgba_pkg::AGG_SUM);
        add_req(hgba_pkg::REQ_CLEAR, '0, '0);
        add_req(hgba_pkg::REQ_AGGREGATE, {INT_MIN, 64'd3, INT_MAX, 64'd1}, INT_MAX);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[r])
        begin
            if (stim_table[r].kind == ROW_CFG)
                write_register(stim_table[r].index, stim_table[r].data);
            else
                send_request(stim_table[r].rtype, stim_table[r].key, stim_table[r].value,
                             stim_table[r].typed, stim_table[r].result);
        end

        // Random phases. Each one picks fresh settings, empties the table and
        // then mostly revisits a small pool of keys so that groups are found
        // again, hash chains form and small tables fill up.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            case ($urandom_range(5))
                0: ec = 64'd1024;
                1: ec = hgba_pkg::word_t'($urandom_range(2047));
                default: ec = hgba_pkg::word_t'($urandom_range(12, 1));
            endcase
            write_register(hgba_pkg::CFG_KEY_WORDS, hgba_pkg::word_t'($urandom_range(7)));
            write_register(hgba_pkg::CFG_ENTRY_COUNT, ec);
            write_register(hgba_pkg::CFG_INIT_VALUE, pick_word());
            write_register(hgba_pkg::CFG_AGG_MODE, hgba_pkg::word_t'($urandom_range(3)));
            for (int k = 0; k < POOL_SIZE; k++)
                key_pool[k] = {pick_word(), pick_word(), pick_word(), pick_word()};
            send_request(hgba_pkg::REQ_CLEAR, '0, '0, 1'b0, none);
            // Once, the receiver stops for a long stretch while requests keep
            // coming, so the output register fills and the input is stalled.
            if (p == 5)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    key = key_pool[$urandom_range(POOL_SIZE - 1)];
                else
                    key = {pick_word(), pick_word(), pick_word(), pick_word()};
                send_request((pick > 96) ? hgba_pkg::REQ_CLEAR : hgba_pkg::REQ_AGGREGATE,
                             key, pick_word(), 1'b0, none);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count = error_count + 1;
            $display("%0t: %0d responses never arrived", $time, pending_results.size());
        end
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/hgba_pkg.sv
src/hgba_req_if.sv
src/hgba_rsp_if.sv
src/hgba_ram.sv
src/hgba_hash.sv
src/hash_group_by_aggregate_unit.sv
src/hgba_checker.sv
tb/hash_group_by_aggregate_unit_tb.sv
